// ----- hw/rtl/gtq_pkg.sv -----
// ----------------------------------------------------------------------------
// gtq_pkg
// shared types and constants of the grouped team queue
// ----------------------------------------------------------------------------
`default_nettype none
package gtq_pkg;
    localparam int ElemW   = 20;
    localparam int TeamW   = 8;
    localparam int KindW   = 2;
    localparam int StatW   = 2;
    localparam int DefMemberEntries = 256;
    localparam int DefQueueDepth    = 256;
    localparam int DefTeamCount     = 255;

    typedef enum logic [KindW-1:0] {
        K_LOAD = 2'd0, K_ENQ = 2'd1, K_DEQ = 2'd2, K_CLR = 2'd3
    } t_kind;

    typedef enum logic [StatW-1:0] {
        S_DEQ = 2'd0, S_QFULL = 2'd1, S_TFULL = 2'd2, S_RSVD = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        F_IDLE, F_SCAN, F_WAIT, F_PUSH
    } t_fstate;

    typedef enum logic [2:0] {
        B_IDLE, B_RD, B_LK, B_EXEC, B_DEQ2, B_OUT
    } t_bstate;
endpackage
`default_nettype wire

// ----- hw/rtl/gtq_if.sv -----
// ----------------------------------------------------------------------------
// gtq_in_if / gtq_out_if
// valid/ready channels of the grouped team queue
// ----------------------------------------------------------------------------
`default_nettype none
interface gtq_in_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              kind;
    logic [19:0]             element;
    logic [7:0]              team;
    modport source (output valid, kind, element, team, input ready);
    modport sink   (input valid, kind, element, team, output ready);
endinterface

interface gtq_out_if;
    logic        valid;
    logic        ready;
    logic [19:0] element_out;
    logic [1:0]  status;
    modport source (output valid, element_out, status, input ready);
    modport sink   (input valid, element_out, status, output ready);
endinterface
`default_nettype wire

// ----- hw/rtl/gtq_ram.sv -----
// ----------------------------------------------------------------------------
// gtq_ram
// generic single write, single read ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none
module gtq_ram #(
    parameter int Width = 8,
    parameter int Depth = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- hw/rtl/gtq_front.sv -----
// ----------------------------------------------------------------------------
// gtq_front
// takes words, keeps the member table, resolves the team of an enqueue
// ----------------------------------------------------------------------------
`default_nettype none
module gtq_front #(
    parameter int MemberEntries = gtq_pkg::DefMemberEntries,
    parameter int TeamCount     = gtq_pkg::DefTeamCount
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    gtq_in_if.sink                         i_in,
    // command towards the back part: kind, element, group
    output logic                           o_cmd_valid,
    input  wire logic                      i_cmd_ready,
    output gtq_pkg::t_kind                 o_cmd_kind,
    output logic [gtq_pkg::ElemW-1:0]      o_cmd_elem,
    output logic [$clog2(TeamCount+1)-1:0] o_cmd_group
);
    import gtq_pkg::*;
    localparam int MA = $clog2(MemberEntries);
    localparam int GW = $clog2(TeamCount+1);
    localparam int MW = ElemW + TeamW;

    t_fstate r_st, n_st;
    logic [MA:0]      r_cnt, n_cnt;
    logic [MA:0]      r_idx, n_idx;
    logic             r_rdv;
    logic [ElemW-1:0] r_elem;
    t_kind            r_kind;
    logic [GW-1:0]    r_best, n_best;
    logic [MW-1:0]    w_rd;
    logic [TeamW-1:0] w_rt;
    logic             w_we, w_hit;

    assign i_in.ready = (r_st == F_IDLE);
    assign w_we = i_in.valid && i_in.ready && t_kind'(i_in.kind) == K_LOAD
                  && r_cnt < (MA+1)'(MemberEntries);

    gtq_ram #(.Width(MW), .Depth(MemberEntries)) u_mem (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_cnt[MA-1:0]),
        .i_wdata({i_in.element, i_in.team}),
        .i_raddr(r_idx[MA-1:0]),
        .o_rdata(w_rd)
    );

    assign w_rt  = w_rd[TeamW-1:0];
    assign w_hit = r_rdv && w_rd[MW-1:TeamW] == r_elem && w_rt != '0
                   && {1'b0, w_rt} <= (TeamW+1)'(TeamCount)
                   && (r_best == '0 || GW'(w_rt) < r_best);

    always_comb begin
        n_st = r_st;
        n_cnt = r_cnt;
        n_idx = r_idx;
        n_best = r_best;
        case (r_st)
            F_IDLE: begin
                n_idx = '0;
                n_best = '0;
                if (i_in.valid) begin
                    if (w_we) n_cnt = r_cnt + 1'b1;
                    if (t_kind'(i_in.kind) == K_CLR) n_cnt = '0;
                    if (t_kind'(i_in.kind) == K_ENQ) n_st = F_SCAN;
                    else if (t_kind'(i_in.kind) != K_LOAD
                             || r_cnt >= (MA+1)'(MemberEntries)) n_st = F_PUSH;
                end
            end
            F_SCAN: begin
                if (w_hit) n_best = GW'(w_rt);
                if (r_idx < r_cnt) n_idx = r_idx + 1'b1;
                else if (!r_rdv) n_st = F_PUSH;
            end
            F_PUSH: begin
                if (i_cmd_ready) n_st = F_IDLE;
            end
            default: n_st = F_IDLE;
        endcase
    end

    always_comb begin
        o_cmd_valid = (r_st == F_PUSH);
        o_cmd_kind  = r_kind;
        o_cmd_elem  = r_elem;
        o_cmd_group = r_best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= F_IDLE;
            r_cnt <= '0;
            r_rdv <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_cnt <= n_cnt;
            r_rdv <= (r_st == F_SCAN) && r_idx < r_cnt;
        end
        r_idx  <= n_idx;
        r_best <= n_best;
        if (r_st == F_IDLE && i_in.valid) begin
            r_elem <= i_in.element;
            r_kind <= t_kind'(i_in.kind);
        end
    end

    a_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (MA+1)'(MemberEntries)) else $error("member count overflow");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid && !i_cmd_ready |=> o_cmd_valid && $stable(o_cmd_group))
        else $error("command dropped");
    a_rdy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_valid |-> !i_in.ready) else $error("front overlap");
endmodule
`default_nettype wire

// ----- hw/rtl/gtq_back.sv -----
// ----------------------------------------------------------------------------
// gtq_back
// runs enqueue, dequeue and clear on the linked slot memory, reports dropped loads
// ----------------------------------------------------------------------------
`default_nettype none
module gtq_back #(
    parameter int QueueDepth = gtq_pkg::DefQueueDepth,
    parameter int TeamCount  = gtq_pkg::DefTeamCount
) (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_cmd_valid,
    output logic                           o_cmd_ready,
    input  gtq_pkg::t_kind                 i_cmd_kind,
    input  wire logic [gtq_pkg::ElemW-1:0] i_cmd_elem,
    input  wire logic [$clog2(TeamCount+1)-1:0] i_cmd_group,
    gtq_out_if.source                      o_out
);
    import gtq_pkg::*;
    localparam int QA = $clog2(QueueDepth);
    localparam int GW = $clog2(TeamCount+1);
    localparam int Groups = TeamCount + 1;

    t_bstate r_st, n_st;
    t_kind            r_kind;
    logic [ElemW-1:0] r_elem;
    logic [GW-1:0]    r_grp;
    logic [QA:0]      r_qcnt;
    logic [QA:0]      r_fresh;      // never-used slots handed out so far
    logic [GW-1:0]    r_oh, r_ot;
    logic [Groups-1:0] r_wait;
    logic [QA-1:0]    r_slot;
    logic             r_ov;
    logic [ElemW-1:0] r_oe;
    t_status          r_os;

    // slot memories, team order ring, team head and tail, free stack, one port pair each
    logic             w_ewe, w_nwe, w_fwe, w_owe, w_hwe, w_twe;
    logic [QA-1:0]    w_ewa, w_nwa, w_nwd, w_era, w_nra, w_fwa, w_fwd, w_fra;
    logic [QA-1:0]    w_hwd, w_hrd, w_trd;
    logic [ElemW-1:0] w_erd;
    logic [QA-1:0]    w_nrd, w_frd, w_newslot;
    logic [GW-1:0]    w_ord, w_ora, w_g;

    gtq_ram #(.Width(ElemW), .Depth(QueueDepth)) u_elem (
        .i_clk(i_clk), .i_we(w_ewe), .i_waddr(w_ewa), .i_wdata(r_elem),
        .i_raddr(w_era), .o_rdata(w_erd));
    gtq_ram #(.Width(QA), .Depth(QueueDepth)) u_next (
        .i_clk(i_clk), .i_we(w_nwe), .i_waddr(w_nwa), .i_wdata(w_nwd),
        .i_raddr(w_nra), .o_rdata(w_nrd));
    gtq_ram #(.Width(QA), .Depth(QueueDepth)) u_free (
        .i_clk(i_clk), .i_we(w_fwe), .i_waddr(w_fwa), .i_wdata(w_fwd),
        .i_raddr(w_fra), .o_rdata(w_frd));
    gtq_ram #(.Width(GW), .Depth(Groups)) u_order (
        .i_clk(i_clk), .i_we(w_owe), .i_waddr(r_ot), .i_wdata(r_grp),
        .i_raddr(w_ora), .o_rdata(w_ord));
    gtq_ram #(.Width(QA), .Depth(Groups)) u_head (
        .i_clk(i_clk), .i_we(w_hwe), .i_waddr(w_g), .i_wdata(w_hwd),
        .i_raddr(w_g), .o_rdata(w_hrd));
    gtq_ram #(.Width(QA), .Depth(Groups)) u_tail (
        .i_clk(i_clk), .i_we(w_twe), .i_waddr(r_grp), .i_wdata(w_newslot),
        .i_raddr(w_g), .o_rdata(w_trd));

    // free stack holds recycled slots below r_fresh; fresh ones count up
    logic [QA:0] w_sp;
    assign w_sp = r_fresh - r_qcnt;  // recycled entries
    assign w_fra = QA'(w_sp - 1'b1);
    assign w_newslot = (w_sp == '0) ? QA'(r_fresh) : w_frd;
    assign w_ora = r_oh;
    assign w_g   = (r_kind == K_ENQ) ? r_grp : w_ord;
    assign w_era = w_hrd;
    assign w_nra = w_hrd;

    logic w_full, w_enq_ok, w_deq_ok;
    assign w_full = r_qcnt >= (QA+1)'(QueueDepth);
    assign o_cmd_ready = (r_st == B_IDLE) && !r_ov;

    always_comb begin
        n_st = r_st;
        case (r_st)
            B_IDLE: if (i_cmd_valid && !r_ov) n_st = B_RD;
            B_RD: n_st = B_LK;
            B_LK: n_st = B_EXEC;
            B_EXEC: n_st = (r_kind == K_DEQ && r_qcnt != '0) ? B_DEQ2 : B_IDLE;
            B_DEQ2: n_st = B_IDLE;
            default: n_st = B_IDLE;
        endcase
    end

    assign w_enq_ok = r_st == B_EXEC && r_kind == K_ENQ && !w_full;
    assign w_deq_ok = r_st == B_EXEC && r_kind == K_DEQ && r_qcnt != '0;
    always_comb begin
        w_ewe = w_enq_ok;
        w_ewa = w_newslot;
        w_nwe = w_enq_ok && r_wait[r_grp];
        w_nwa = w_trd;
        w_nwd = w_newslot;
        w_owe = w_enq_ok && !r_wait[r_grp];
        w_fwe = r_st == B_DEQ2;
        w_fwa = QA'(w_sp);
        w_fwd = r_slot;
        w_twe = w_enq_ok;
        w_hwe = (w_enq_ok && !r_wait[r_grp]) || (w_deq_ok && w_hrd != w_trd);
        w_hwd = (r_kind == K_ENQ) ? w_newslot : w_nrd;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_qcnt <= '0;
            r_fresh <= '0;
            r_oh <= '0;
            r_ot <= '0;
            r_wait <= '0;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            if (o_out.valid && o_out.ready) r_ov <= 1'b0;
            if (r_st == B_EXEC) begin
                case (r_kind)
                    K_CLR: begin
                        r_qcnt <= '0; r_fresh <= '0; r_oh <= '0; r_ot <= '0;
                        r_wait <= '0;
                    end
                    K_ENQ: begin
                        if (w_full) begin
                            r_ov <= 1'b1;
                        end else begin
                            r_qcnt <= r_qcnt + 1'b1;
                            if (w_sp == '0) r_fresh <= r_fresh + 1'b1;
                            if (!r_wait[r_grp]) begin
                                r_wait[r_grp] <= 1'b1;
                                r_ot <= (r_ot == GW'(TeamCount)) ? '0 : r_ot + 1'b1;
                            end
                        end
                    end
                    K_DEQ: begin
                        if (r_qcnt != '0) begin
                            r_ov <= 1'b1;
                            if (w_hrd == w_trd) begin
                                r_wait[w_ord] <= 1'b0;
                                r_oh <= (r_oh == GW'(TeamCount)) ? '0 : r_oh + 1'b1;
                            end
                        end
                    end
                    default: r_ov <= 1'b1;
                endcase
            end
            if (r_st == B_DEQ2) r_qcnt <= r_qcnt - 1'b1;
        end
        if (r_st == B_IDLE && i_cmd_valid) begin
            r_kind <= i_cmd_kind;
            r_elem <= i_cmd_elem;
            r_grp  <= i_cmd_group;
        end
        if (r_st == B_EXEC) begin
            r_slot <= w_hrd;
            r_oe <= '0;
            case (r_kind)
                K_ENQ: r_os <= S_QFULL;
                K_LOAD: r_os <= S_TFULL;
                default: begin
                    r_os <= S_DEQ;
                    r_oe <= w_erd;
                end
            endcase
        end
    end

    assign o_out.valid = r_ov && r_st != B_DEQ2;
    assign o_out.element_out = r_oe;
    assign o_out.status = r_os;

    a_q: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_qcnt <= (QA+1)'(QueueDepth)) else $error("queue count overflow");
    a_fr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fresh >= r_qcnt) else $error("free accounting broken");
    a_ack: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> !r_ov) else $error("result overrun");
endmodule
`default_nettype wire

// ----- hw/rtl/grouped_team_queue.sv -----
// ----------------------------------------------------------------------------
// grouped_team_queue
// team queue with member table lookup and linked slot memory
// ----------------------------------------------------------------------------
// words enter on i_in (kind, element, team) and results leave on o_out
// (element_out, status). load appends to the member table, enqueue places
// the element behind its team's waiting run or at the tail, dequeue returns
// the head, clear empties queue and table. drops report status 1 or 2.
// a load that fits stays in the front part and needs no back work.
// an enqueue scans the member table one entry a cycle, then hands its
// command over. the back part takes a command and works it in steps (read
// order, look up team head and tail, read slot memory, execute); a dequeue
// that frees a slot adds a step that pushes the slot on the free stack,
// and its element is presented only after that step.
// one command register parts front and back; while a result waits on
// o_out the back part holds and the front stalls once its command is full.
// reset is synchronous: both tables and the queue read as empty at once.
// ----------------------------------------------------------------------------
`default_nettype none
module grouped_team_queue #(
    parameter int MEMBER_ENTRIES = gtq_pkg::DefMemberEntries,
    parameter int QUEUE_DEPTH    = gtq_pkg::DefQueueDepth,
    parameter int TEAM_COUNT     = gtq_pkg::DefTeamCount
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    gtq_in_if.sink    i_in,
    gtq_out_if.source o_out
);
    import gtq_pkg::*;
    localparam int GW = $clog2(TEAM_COUNT+1);
    logic             w_cv, w_cr;
    t_kind            w_ck;
    logic [ElemW-1:0] w_ce;
    logic [GW-1:0]    w_cg;

    gtq_front #(.MemberEntries(MEMBER_ENTRIES), .TeamCount(TEAM_COUNT)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_cmd_valid(w_cv), .i_cmd_ready(w_cr), .o_cmd_kind(w_ck),
        .o_cmd_elem(w_ce), .o_cmd_group(w_cg));

    gtq_back #(.QueueDepth(QUEUE_DEPTH), .TeamCount(TEAM_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cv), .o_cmd_ready(w_cr), .i_cmd_kind(w_ck),
        .i_cmd_elem(w_ce), .i_cmd_group(w_cg), .o_out(o_out));
endmodule
`default_nettype wire
